// ----- design/nsa_pkg.sv -----
`timescale 1ns / 1ps

package nsa_pkg;

    // Item kinds carried on s_tuser
    localparam logic [1:0] FUNC_LOAD = 2'd0;
    localparam logic [1:0] FUNC_CHAR = 2'd1;
    localparam logic [1:0] FUNC_END  = 2'd2;

    // Register indexes (byte address = 4 * index)
    localparam logic [1:0] REG_START_STATE      = 2'd0;
    localparam logic [1:0] REG_FINAL_MASK       = 2'd1;
    localparam logic [1:0] REG_TRANSITION_COUNT = 2'd2;

    localparam int STATE_W  = 4;
    localparam int SYMBOL_W = 8;
    localparam int SLOT_W   = 5;
    localparam int MASK_W   = 16;
    localparam int COUNT_W  = 6;

    typedef struct packed {
        logic [STATE_W-1:0] start_state;
        logic [MASK_W-1:0]  final_mask;
        logic [COUNT_W-1:0] transition_count;
    } cfg_t;

    typedef struct packed {
        logic write_rule;   // store the input rule in its table slot
        logic load_set;     // seed the working set, latch the byte
        logic advance;      // take one epsilon pass
        logic step;         // consume the latched byte
        logic report;       // latch the acceptance result, restart
    } cmd_t;

    typedef struct packed {
        logic closure_done; // next pass would add no state
    } sts_t;

endpackage

// ----- design/nsa_regs.sv -----
`timescale 1ns / 1ps

module nsa_regs
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output nsa_pkg::cfg_t      cfg
);

    logic [nsa_pkg::STATE_W-1:0] start_reg;
    logic [nsa_pkg::MASK_W-1:0]  final_reg;
    logic [nsa_pkg::COUNT_W-1:0] count_reg;
    logic                        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg <= '0;
            final_reg <= '0;
            count_reg <= '0;
        end
        else if (wr_en)
        begin
            case (paddr[3:2])
                nsa_pkg::REG_START_STATE:      start_reg <= pwdata[nsa_pkg::STATE_W-1:0];
                nsa_pkg::REG_FINAL_MASK:       final_reg <= pwdata[nsa_pkg::MASK_W-1:0];
                nsa_pkg::REG_TRANSITION_COUNT: count_reg <= pwdata[nsa_pkg::COUNT_W-1:0];
                default:                       ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            nsa_pkg::REG_START_STATE:      prdata = 32'(start_reg);
            nsa_pkg::REG_FINAL_MASK:       prdata = 32'(final_reg);
            nsa_pkg::REG_TRANSITION_COUNT: prdata = 32'(count_reg);
            default:                       prdata = '0;
        endcase
    end

    assign cfg.start_state      = start_reg;
    assign cfg.final_mask       = final_reg;
    assign cfg.transition_count = count_reg;

endmodule

// ----- design/nsa_ctrl.sv -----
`timescale 1ns / 1ps

module nsa_ctrl
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [1:0]    s_tuser,
    output logic          m_tvalid,
    input  logic          m_tready,
    output nsa_pkg::cmd_t cmd,
    input  nsa_pkg::sts_t sts
);

    typedef enum logic [1:0]
    {
        ST_IDLE  = 2'b01,
        ST_CLOSE = 2'b10
    } state_t;

    state_t     state_reg, state_next;
    logic [1:0] func_reg, func_next;
    logic       out_valid_reg, out_valid_next;
    logic       accept;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;

    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        func_next      = func_reg;
        out_valid_next = out_valid_reg && !m_tready;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (s_tuser == nsa_pkg::FUNC_LOAD)
                    begin
                        cmd.write_rule = 1'b1;
                    end
                    else if (s_tuser inside {nsa_pkg::FUNC_CHAR, nsa_pkg::FUNC_END})
                    begin
                        cmd.load_set = 1'b1;
                        func_next    = s_tuser;
                        state_next   = ST_CLOSE;
                    end
                end
            end
            ST_CLOSE:
            begin
                if (!sts.closure_done)
                begin
                    cmd.advance = 1'b1;
                end
                else if (func_reg == nsa_pkg::FUNC_CHAR)
                begin
                    cmd.step   = 1'b1;
                    state_next = ST_IDLE;
                end
                else if (!out_valid_reg || m_tready)
                begin
                    // hold here while the previous result is still waiting
                    cmd.report     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            func_reg      <= nsa_pkg::FUNC_LOAD;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            func_reg      <= func_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ----- design/nsa_datapath.sv -----
`timescale 1ns / 1ps

module nsa_datapath
#(
    parameter int SET_W     = 16,
    parameter int TBL_DEPTH = 32
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  nsa_pkg::cmd_t                  cmd,
    output nsa_pkg::sts_t                  sts,
    input  nsa_pkg::cfg_t                  cfg,
    input  logic [nsa_pkg::SLOT_W-1:0]     rule_slot,
    input  logic [nsa_pkg::STATE_W-1:0]    source_state,
    input  logic [nsa_pkg::STATE_W-1:0]    target_state,
    input  logic [nsa_pkg::SYMBOL_W-1:0]   rule_symbol,
    input  logic                           rule_is_epsilon,
    input  logic [nsa_pkg::SYMBOL_W-1:0]   char_value,
    output logic                           accepted
);

    // Transition table, one flop row per slot, no reset
    logic [nsa_pkg::STATE_W-1:0]  rule_src_reg [TBL_DEPTH];
    logic [nsa_pkg::STATE_W-1:0]  rule_dst_reg [TBL_DEPTH];
    logic [nsa_pkg::SYMBOL_W-1:0] rule_sym_reg [TBL_DEPTH];
    logic                         rule_eps_reg [TBL_DEPTH];

    logic [SET_W-1:0]             set_reg;
    logic [SET_W-1:0]             active_reg;
    logic                         at_start_reg;
    logic [nsa_pkg::SYMBOL_W-1:0] char_reg;
    logic                         acc_reg;

    logic [SET_W-1:0] start_oh;
    logic [SET_W-1:0] closure_next;
    logic [SET_W-1:0] step_next;

    always_comb
    begin
        for (int j = 0; j < SET_W; j++)
        begin
            start_oh[j] = (cfg.start_state == nsa_pkg::STATE_W'(j));
        end
    end

    // All slots compared in parallel against the working set
    always_comb
    begin
        logic [SET_W-1:0] src_oh;
        logic [SET_W-1:0] dst_oh;
        logic             live;
        closure_next = set_reg;
        step_next    = '0;
        for (int i = 0; i < TBL_DEPTH; i++)
        begin
            for (int j = 0; j < SET_W; j++)
            begin
                src_oh[j] = (rule_src_reg[i] == nsa_pkg::STATE_W'(j));
                dst_oh[j] = (rule_dst_reg[i] == nsa_pkg::STATE_W'(j));
            end
            live = (cfg.transition_count > nsa_pkg::COUNT_W'(i)) && (|(set_reg & src_oh));
            if (live && rule_eps_reg[i])
            begin
                closure_next = closure_next | dst_oh;
            end
            if (live && !rule_eps_reg[i] && (rule_sym_reg[i] == char_reg))
            begin
                step_next = step_next | dst_oh;
            end
        end
    end

    assign sts.closure_done = (closure_next == set_reg);

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < TBL_DEPTH; i++)
        begin
            if (cmd.write_rule && (rule_slot == nsa_pkg::SLOT_W'(i)))
            begin
                rule_src_reg[i] <= source_state;
                rule_dst_reg[i] <= target_state;
                rule_sym_reg[i] <= rule_symbol;
                rule_eps_reg[i] <= rule_is_epsilon;
            end
        end
        if (cmd.load_set)
        begin
            set_reg  <= at_start_reg ? start_oh : active_reg;
            char_reg <= char_value;
        end
        else if (cmd.advance)
        begin
            set_reg <= closure_next;
        end
        if (cmd.report)
        begin
            acc_reg <= |(set_reg & cfg.final_mask[SET_W-1:0]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg   <= '0;
            at_start_reg <= 1'b1;
        end
        else if (cmd.step)
        begin
            active_reg   <= step_next;
            at_start_reg <= 1'b0;
        end
        else if (cmd.report)
        begin
            active_reg   <= '0;
            at_start_reg <= 1'b1;
        end
    end

    assign accepted = acc_reg;

endmodule

// ----- design/nfa_string_acceptor.sv -----
`timescale 1ns / 1ps

// NFA string acceptor with epsilon moves.
// Slave stream: s_tuser selects the item kind (load rule, consume byte, end
// of string); s_tdata carries the rule fields and the byte. Master stream:
// one item per end-of-string item, m_tdata[0] = accepted.
// APB port: start_state at 0x0, final_mask at 0x4, transition_count at 0x8.
// Load items are written to the table and s_tready stays high. A byte or end
// item loads the working set, then takes P epsilon passes, where P (0 to
// SET_W - 1) is the number of passes that still add states; each pass
// compares every table slot in parallel. It then steps on the byte or reports.
// s_tready is low while an item is in the closure loop. The result sits in
// an output register; a waiting result does not block the next item, but a
// second end item holds in the loop until the first result is taken.
// Reset clears the registers, the active set and the output valid, and
// arms a restart at start_state. Table contents are undefined until written.

module nfa_string_acceptor
#(
    parameter int NUM_STATES      = 16,
    parameter int NUM_TRANSITIONS = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    // APB configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input items
    input  logic        s_tvalid,
    output logic        s_tready,
    // [4:0] rule slot, [8:5] source_state, [12:9] target_state,
    // [20:13] rule_symbol, [21] rule_is_epsilon, [29:22] char_value, [31:30] zero
    input  logic [31:0] s_tdata,
    // [1:0] func
    input  logic [1:0]  s_tuser,
    // result items
    output logic        m_tvalid,
    input  logic        m_tready,
    // [0] accepted, [7:1] zero
    output logic [7:0]  m_tdata
);

    // Only 4-bit states and 5-bit slots are addressable
    localparam int SET_W     = (NUM_STATES < 16) ? NUM_STATES : 16;
    localparam int TBL_DEPTH = (NUM_TRANSITIONS < 32) ? NUM_TRANSITIONS : 32;

    nsa_pkg::cfg_t cfg;
    nsa_pkg::cmd_t cmd;
    nsa_pkg::sts_t sts;
    logic          accepted;

    nsa_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Sequence accept, closure passes, step or report
    nsa_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    // Table, working set and result register
    nsa_datapath
    #(
        .SET_W     (SET_W),
        .TBL_DEPTH (TBL_DEPTH)
    )
    u_datapath
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .sts             (sts),
        .cfg             (cfg),
        .rule_slot       (s_tdata[4:0]),
        .source_state    (s_tdata[8:5]),
        .target_state    (s_tdata[12:9]),
        .rule_symbol     (s_tdata[20:13]),
        .rule_is_epsilon (s_tdata[21]),
        .char_value      (s_tdata[29:22]),
        .accepted        (accepted)
    );

    assign m_tdata = {7'd0, accepted};

endmodule

// ----- design/nsa_checker.sv -----
`timescale 1ns / 1ps

module nsa_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic [1:0] s_tuser,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata
);

    // A waiting result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result changed while stalled");

    // A byte or end item always enters the closure loop
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready &&
        (s_tuser == nsa_pkg::FUNC_CHAR || s_tuser == nsa_pkg::FUNC_END) |=> !s_tready)
        else $error("input not held off during closure");

    // A rule load never stalls the input
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tuser == nsa_pkg::FUNC_LOAD |=> s_tready)
        else $error("input stalled after rule load");

    // A new result only leaves the closure loop
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result raised outside closure loop");

endmodule

bind nfa_string_acceptor nsa_checker u_nsa_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
